[hdl/cidr_pkg.sv]
package cidr_pkg;

   localparam int BEAT_BYTES          = 8;
   localparam int DEF_MAX_FRAME_BYTES = 256;
   localparam int FILL_W_MAX          = 13;
   localparam int FRAME_LEN_W         = 9;
   localparam int CMD_DEPTH           = 4;
   localparam int OUT_DEPTH           = 4;
   localparam int OUT_CNT_W           = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_BASE_ID   = 2'd0,
      CSR_FD_MODE   = 2'd1,
      CSR_FRAME_LEN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [28:0]            base_id;
      logic                   fd_mode;
      logic [FRAME_LEN_W-1:0] frame_len;
   } cfg_type;

   typedef struct packed {
      logic [28:0] can_id;
      logic [6:0]  pkt_len;
      logic [63:0] beat_data;
      logic        beat_last;
   } req_item_type;

   typedef struct packed {
      logic [63:0] frame_word;
      logic        word_last;
      logic [31:0] lost_count;
   } rsp_item_type;

   // Work for the back end: store a run of bytes, then optionally emit the frame.
   typedef struct packed {
      logic                  wr;
      logic                  emit;
      logic [3:0]            nbytes;
      logic [FILL_W_MAX-1:0] offset;
      logic [FILL_W_MAX-1:0] frame_bytes;
      logic [63:0]           data;
      logic [31:0]           lost;
   } cmd_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_EMIT = 1'b1
   } back_state_type;

endpackage

[hdl/cidr_fifo.sv]
module cidr_fifo
   import cidr_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count    = count_ff;
   assign pop_data = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/cidr_front.sv]
module cidr_front
   import cidr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   input  req_item_type req_data,
   input  logic         cmd_full,
   output logic         full,
   output logic         cmd_push,
   output cmd_type      cmd_data
);

   localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CMP_W  = (FILL_W > FRAME_LEN_W) ? FILL_W : FRAME_LEN_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FRAME_BYTES);
   localparam logic [6:0] POS_STEP      = 7'd8;
   localparam logic [6:0] POS_SAT       = 7'd120;
   localparam logic [6:0] CLASSIC_LIMIT = 7'd8;
   localparam logic [6:0] FD_LIMIT      = 7'd64;

   logic [6:0]        pos_ff, pos_in;
   logic              skip_ff, skip_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [5:0]        exp_ff, exp_in;
   logic [31:0]       lost_ff, lost_in;

   logic              accept, first, len_bad, seq_match;
   logic [28:0]       seq;
   logic [CMP_W-1:0]  len_x, n_x;
   logic [FILL_W-1:0] n, fill_a, fill_b, room_w;
   logic [5:0]        exp_a;
   logic              skip_a;
   logic [1:0]        lost_inc;
   logic [31:0]       lost_a;
   logic [6:0]        avail_w;
   logic [3:0]        avail8, room8, nbytes;
   logic              emit;

   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   always_comb begin
      // clamp the frame length to 1..MAX_FRAME_BYTES
      len_x = CMP_W'(cfg.frame_len);
      if (len_x == '0) begin
         n_x = CMP_W'(1);
      end else if (len_x > MAX_CMP) begin
         n_x = MAX_CMP;
      end else begin
         n_x = len_x;
      end
      n = n_x[FILL_W-1:0];

      first     = (pos_ff == '0);
      len_bad   = (req_data.pkt_len == '0) ||
                  (req_data.pkt_len > (cfg.fd_mode ? FD_LIMIT : CLASSIC_LIMIT));
      seq       = req_data.can_id - cfg.base_id;
      seq_match = (seq == 29'(exp_ff));

      fill_a   = fill_ff;
      exp_a    = exp_ff;
      skip_a   = skip_ff;
      lost_inc = 2'd0;
      if (first) begin
         skip_a = 1'b0;
         if (len_bad) begin
            skip_a = 1'b1;
         end else if (!seq_match) begin
            // drop the partial frame; a packet that is not a frame start is lost too
            if (fill_ff != '0) begin
               lost_inc = lost_inc + 2'd1;
            end
            fill_a = '0;
            exp_a  = '0;
            if (seq != '0) begin
               lost_inc = lost_inc + 2'd1;
               skip_a   = 1'b1;
            end
         end
      end
      lost_a = lost_ff + 32'(lost_inc);

      avail_w = (req_data.pkt_len > pos_ff) ? req_data.pkt_len - pos_ff : '0;
      avail8  = (avail_w > 7'd8) ? 4'd8 : avail_w[3:0];
      room_w  = (n > fill_a) ? n - fill_a : '0;
      room8   = (room_w > FILL_W'(8)) ? 4'd8 : room_w[3:0];
      nbytes  = skip_a ? 4'd0 : ((avail8 < room8) ? avail8 : room8);
      fill_b  = fill_a + FILL_W'(nbytes);
      emit    = req_data.beat_last && !skip_a && (fill_b >= n);

      fill_in = emit ? '0 : fill_b;
      exp_in  = exp_a;
      if (req_data.beat_last && !skip_a) begin
         exp_in = emit ? '0 : exp_a + 6'd1;
      end
      skip_in = req_data.beat_last ? 1'b0 : skip_a;
      if (req_data.beat_last) begin
         pos_in = '0;
      end else begin
         pos_in = (pos_ff <= POS_SAT - POS_STEP) ? pos_ff + POS_STEP : POS_SAT;
      end
      lost_in = lost_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         skip_ff <= 1'b0;
         fill_ff <= '0;
         exp_ff  <= '0;
         lost_ff <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         fill_ff <= fill_in;
         exp_ff  <= exp_in;
         lost_ff <= lost_in;
      end
   end

   always_comb begin
      cmd_data.wr          = (nbytes != '0);
      cmd_data.emit        = emit;
      cmd_data.nbytes      = nbytes;
      cmd_data.offset      = FILL_W_MAX'(fill_a);
      cmd_data.frame_bytes = FILL_W_MAX'(n);
      cmd_data.data        = req_data.beat_data;
      cmd_data.lost        = lost_a;
      cmd_push             = accept && (cmd_data.wr || emit);
   end

endmodule

[hdl/cidr_back.sv]
module cidr_back
   import cidr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  cmd_type              cmd_data,
   output logic                 cmd_pop,
   input  logic [OUT_CNT_W-1:0] out_count,
   output logic                 out_push,
   output rsp_item_type         out_data
);

   localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int ROWS   = (MAX_FRAME_BYTES + BEAT_BYTES - 1) / BEAT_BYTES;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int WORD_W = $clog2(ROWS + 1);

   back_state_type     state_ff, state_in;
   logic [ROW_W-1:0]   word_ff;
   logic [WORD_W-1:0]  words_ff;
   logic [FILL_W-1:0]  n_ff;
   logic [31:0]        lost_ff;
   logic               rd_valid_ff;
   logic               rd_last_ff;
   logic [7:0]         rd_mask_ff;
   logic [31:0]        rd_lost_ff;

   logic               wr_en, issue, credit_ok, word_last;
   logic [FILL_W-1:0]  cmd_n;
   logic [FILL_W:0]    words_x, rem;
   logic [7:0]         mask;
   logic [63:0]        rd_word;

   assign credit_ok = ({1'b0, out_count} + (OUT_CNT_W + 1)'(rd_valid_ff))
                      < (OUT_CNT_W + 1)'(OUT_DEPTH);
   assign word_last = ((WORD_W'(word_ff) + WORD_W'(1)) == words_ff);
   assign cmd_n     = cmd_data.frame_bytes[FILL_W-1:0];
   assign words_x   = ((FILL_W + 1)'(cmd_n) + (FILL_W + 1)'(BEAT_BYTES - 1)) >> 3;
   assign rem       = (FILL_W + 1)'(n_ff) - (FILL_W + 1)'({word_ff, 3'b000});

   always_comb begin
      for (int i = 0; i < BEAT_BYTES; i++) begin
         mask[i] = (rem > (FILL_W + 1)'(i));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty && cmd_data.emit) begin
               state_in = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (credit_ok && word_last) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      case (state_ff)
         BACK_IDLE: cmd_pop = !cmd_empty;
         BACK_EMIT: issue   = credit_ok;
         default: begin
            cmd_pop = 1'b0;
            issue   = 1'b0;
         end
      endcase
      wr_en = cmd_pop && cmd_data.wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BACK_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.emit) begin
         word_ff  <= '0;
         words_ff <= words_x[WORD_W-1:0];
         n_ff     <= cmd_n;
         lost_ff  <= cmd_data.lost;
      end else if (issue) begin
         word_ff <= word_ff + ROW_W'(1);
      end
      if (issue) begin
         rd_last_ff <= word_last;
         rd_mask_ff <= mask;
         rd_lost_ff <= lost_ff;
      end
   end

   // one byte-wide bank per lane; byte i of the frame lives in lane i%8, row i/8
   for (genvar L = 0; L < BEAT_BYTES; L++) begin : g_lane
      logic [7:0]      mem [ROWS];
      logic [7:0]      rd_byte_ff;
      logic [2:0]      src;
      logic [FILL_W:0] addr;
      logic            we;

      assign src  = 3'(L) - cmd_data.offset[2:0];
      assign addr = (FILL_W + 1)'(cmd_data.offset[FILL_W-1:0]) + (FILL_W + 1)'(src);
      assign we   = wr_en && ({1'b0, src} < cmd_data.nbytes);

      always_ff @(posedge clock) begin
         if (we) begin
            mem[addr[ROW_W+2:3]] <= cmd_data.data[8*src +: 8];
         end
         if (issue) begin
            rd_byte_ff <= mem[word_ff];
         end
      end

      assign rd_word[8*L +: 8] = rd_byte_ff & {8{rd_mask_ff[L]}};
   end

   assign out_push            = rd_valid_ff;
   assign out_data.frame_word = rd_word;
   assign out_data.word_last  = rd_last_ff;
   assign out_data.lost_count = rd_lost_ff;

endmodule

[hdl/can_id_sequence_reassembler.sv]
// Flow: a beat is taken in a cycle where push is high and full low; the first word of a
// frame reaches rsp_data through the command queue, the frame writer's read register
// and the result queue, then one word a cycle while pop keeps up.
// Throughput: one beat per cycle until the 4-entry command queue fills; the frame
// writer drains one command a cycle, but pauses on each emit while it streams the frame out.
// Reset: synchronous, active high; clears queues, sequence tracking and the lost count.
module can_id_sequence_reassembler
   import cidr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   // beat input, queue style
   input  logic         push,
   output logic         full,
   input  req_item_type req_data,
   // frame words out, queue style
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_data,
   // register writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [28:0]  csr_wdata
);

   // Configuration. The user must write it only while the block is idle; the block does not enforce this.
   logic [28:0]            base_id_ff;
   logic                   fd_mode_ff;
   logic [FRAME_LEN_W-1:0] frame_len_ff;
   cfg_type                cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff   <= '0;
         fd_mode_ff   <= 1'b0;
         frame_len_ff <= FRAME_LEN_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_ID:   base_id_ff   <= csr_wdata;
            CSR_FD_MODE:   fd_mode_ff   <= csr_wdata[0];
            CSR_FRAME_LEN: frame_len_ff <= csr_wdata[FRAME_LEN_W-1:0];
            default:       ;
         endcase
      end
   end

   assign cfg.base_id   = base_id_ff;
   assign cfg.fd_mode   = fd_mode_ff;
   assign cfg.frame_len = frame_len_ff;

   // Front: check each packet's length and sequence, track the frame fill,
   // and turn every accepted beat into at most one store/emit command.
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_in, cmd_out;
   logic [$clog2(CMD_DEPTH + 1)-1:0] cmd_count;

   cidr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .req_data (req_data),
      .cmd_full (cmd_full),
      .full     (full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   // Command queue: lets the front keep taking beats while a frame drains.
   cidr_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .count     (cmd_count)
   );

   // Back: hold the frame bytes in lane banks and stream a finished frame out.
   logic                 out_push, out_full;
   logic [OUT_CNT_W-1:0] out_count;
   rsp_item_type         out_item;

   cidr_back #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_item)
   );

   // Result queue: the back end reserves a slot before each read, so no push is lost.
   cidr_fifo #(
      .WIDTH($bits(rsp_item_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty),
      .full      (out_full),
      .count     (out_count)
   );

   // A full result queue only stalls reads; the credit check already covers it.
   // The command queue's fill level is not needed either.
   logic out_unused;
   assign out_unused = out_full | (|cmd_count);

endmodule

[hdl/cidr_checker.sv]
module cidr_checker
   import cidr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_data
);

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not cleared by reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting item changed or vanished");

   a_lost_in_frame: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_data.word_last) |=>
      (empty || (rsp_data.lost_count == $past(rsp_data.lost_count))))
      else $error("lost count changed inside a frame");

endmodule

bind can_id_sequence_reassembler cidr_checker u_checker (.*);
